### hdl/ica_pkg.sv
// Shared types, constants and arctangent table for the attitude estimator.
`timescale 1ns / 1ps
package ica_pkg;

  localparam int CordicSteps = 16;
  localparam int TableLen = 24;
  localparam int RunSteps = (CordicSteps < TableLen) ? CordicSteps : TableLen;
  localparam int StepW = $clog2(TableLen);
  localparam int SqrtSteps = 24;
  localparam int SqrtCntW = 5;

  localparam int CordW = 36;
  localparam int ZW = 26;

  localparam logic [15:0] TimeStepReset = 16'd3277;
  localparam logic [15:0] AccelWeightReset = 16'd64225;
  localparam logic signed [16:0] AngLimit = 17'sd46080;

  typedef enum logic {
    REG_TIME_STEP = 1'b0,
    REG_ACCEL_WEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic load;
    logic sqrt_step;
    logic cordic_init_a;
    logic cordic_init_b;
    logic cordic_step;
    logic mult_a;
    logic mult_b;
    logic finish;
    logic finish_roll;
  } ica_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic cordic_done;
  } ica_status_t;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [StepW-1:0] idx);
    logic signed [ZW-1:0] v;
    v = '0;
    unique case (idx)
      5'd0: v = 26'sd2949120;
      5'd1: v = 26'sd1740967;
      5'd2: v = 26'sd919879;
      5'd3: v = 26'sd466945;
      5'd4: v = 26'sd234379;
      5'd5: v = 26'sd117304;
      5'd6: v = 26'sd58666;
      5'd7: v = 26'sd29335;
      5'd8: v = 26'sd14668;
      5'd9: v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hdl/imu_complementary_attitude.sv
// Top level of the complementary attitude estimator.
//   channel | signals                                   | direction
//   in      | in_valid/in_ready, accel_*, gyro_*        | input
//   out     | out_valid/out_ready, *_new, *_prev        | output
//   cfg     | cfg_we, cfg_index, cfg_data               | input
// out_valid rises after an input transfer once the sample has run through 24
// square-root steps and a done check, two CORDIC runs of 16 iterations with a
// load and a done check each, then pitch blend, pitch/yaw update and roll update with hand-off.
// A tilt whose two operands are both zero skips its 16 iterations.
// Reset sets time_step and accel_weight to defaults and clears the angles.
// The next sample is taken only once the previous result has been transferred.
`timescale 1ns / 1ps
module imu_complementary_attitude (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [23:0] yaw_new,
  output logic signed [16:0] pitch_new,
  output logic signed [16:0] roll_new,
  output logic signed [23:0] yaw_prev,
  output logic signed [16:0] pitch_prev,
  output logic signed [16:0] roll_prev,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [15:0] cfg_data
);

  ica_pkg::ica_cmd_t cmd;
  ica_pkg::ica_status_t status;

  ica_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .cmd(cmd), .status(status)
  );

  ica_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z),
    .yaw_new(yaw_new), .pitch_new(pitch_new), .roll_new(roll_new),
    .yaw_prev(yaw_prev), .pitch_prev(pitch_prev), .roll_prev(roll_prev)
  );

endmodule

### hdl/ica_ctrl.sv
// Sequencer for one sample: square root, two CORDIC runs, blend and hand-off.
`timescale 1ns / 1ps
module ica_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output ica_pkg::ica_cmd_t cmd,
  input  ica_pkg::ica_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE, S_SQRT, S_CORD_A, S_MULT_A, S_CORD_B, S_MULT_B, S_DONE, S_ROLL
  } state_t;

  state_t state;
  logic cinit;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    cmd.sqrt_step = (state == S_SQRT);
    cmd.cordic_init_a = (state == S_CORD_A) && cinit;
    cmd.cordic_init_b = (state == S_CORD_B) && cinit;
    cmd.cordic_step = ((state == S_CORD_A) || (state == S_CORD_B)) && !cinit;
    cmd.mult_a = (state == S_MULT_A);
    cmd.mult_b = (state == S_MULT_B);
    cmd.finish = (state == S_DONE);
    cmd.finish_roll = (state == S_ROLL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      cinit <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (status.sqrt_done) begin
            state <= S_CORD_A;
            cinit <= 1'b1;
          end
        end
        S_CORD_A: begin
          cinit <= 1'b0;
          if (!cinit && status.cordic_done) begin
            state <= S_MULT_A;
          end
        end
        S_MULT_A: begin
          state <= S_CORD_B;
          cinit <= 1'b1;
        end
        S_CORD_B: begin
          cinit <= 1'b0;
          if (!cinit && status.cordic_done) begin
            state <= S_MULT_B;
          end
        end
        S_MULT_B: begin
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_ROLL;
        end
        S_ROLL: begin
          state <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_done_raises_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROLL) |=> out_valid) else $error("result lost");
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("valid dropped");
`endif

endmodule

### hdl/ica_datapath.sv
// Datapath: square root, shared CORDIC, blend multipliers and angle state.
`timescale 1ns / 1ps
module ica_datapath (
  input  logic clk,
  input  logic rst,
  input  ica_pkg::ica_cmd_t cmd,
  output ica_pkg::ica_status_t status,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  output logic signed [23:0] yaw_new,
  output logic signed [16:0] pitch_new,
  output logic signed [16:0] roll_new,
  output logic signed [23:0] yaw_prev,
  output logic signed [16:0] pitch_prev,
  output logic signed [16:0] roll_prev
);

  localparam int CW = ica_pkg::CordW;
  localparam int ZW = ica_pkg::ZW;

  logic [15:0] time_step, accel_weight;
  logic signed [23:0] yaw_angle;
  logic signed [16:0] pitch_angle, roll_angle;

  logic signed [15:0] ax, ay, az, gx, gy, gz;

  // Square root, one result bit per step.
  logic [31:0] sq_sum;
  logic [25:0] sq_rem;
  logic [47:0] sq_val;
  logic [23:0] sq_root;
  logic [ica_pkg::SqrtCntW-1:0] sq_cnt;
  logic [27:0] sq_trial_rem;
  logic [27:0] sq_trial;

  // CORDIC
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic [ica_pkg::StepW-1:0] cstep;
  logic signed [CW-1:0] ix, iy;
  logic signed [ZW-1:0] iz;
  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] tilt_a;

  logic signed [32:0] gyro_roll, gyro_pitch;
  logic signed [32:0] g_roll_q, g_pitch_q;
  logic signed [46:0] yaw_acc;
  logic signed [23:0] yaw_sat;
  logic signed [ZW+4:0] prod_tilt_src;
  logic signed [32:0] prod_gyro_src;
  logic signed [16:0] blend_q;
  logic signed [17:0] w_s, gw_s;
  logic signed [48:0] prod_t, prod_g;
  logic signed [49:0] acc;
  logic signed [21:0] acc_r;

  // square root step
  always_comb begin
    sq_sum = 32'($signed(accel_y) * $signed(accel_y))
           + 32'($signed(accel_z) * $signed(accel_z));
    sq_trial_rem = {sq_rem, sq_val[47:46]};
    sq_trial = {2'b00, sq_root, 2'b01};
  end

  assign status.sqrt_done = (sq_cnt == 5'd0);
  assign status.cordic_done = (cstep == ica_pkg::StepW'(ica_pkg::RunSteps));

  // CORDIC operand selection with the pre-rotation for negative x
  always_comb begin
    logic signed [CW-1:0] y0, x0;
    if (cmd.cordic_init_a) begin
      y0 = CW'(-$signed({{(CW-16){ax[15]}}, ax}) <<< 8);
      x0 = CW'({1'b0, sq_root});
    end else begin
      y0 = CW'($signed({{(CW-16){ay[15]}}, ay}) <<< 8);
      x0 = CW'($signed({{(CW-16){az[15]}}, az}) <<< 8);
    end
    ix = x0;
    iy = y0;
    iz = '0;
    if (x0 < 0) begin
      if (y0 >= 0) begin
        ix = y0;
        iy = -x0;
        iz = ZW'(90 * 65536);
      end else begin
        ix = -y0;
        iy = x0;
        iz = -ZW'(90 * 65536);
      end
    end
  end

  assign xs = cx >>> cstep;
  assign ys = cy >>> cstep;

  // blend sources
  always_comb begin
    gyro_roll = ($signed({{16{roll_angle[16]}}, roll_angle}) <<< 12)
              + $signed({{17{gx[15]}}, gx}) * $signed({17'd0, time_step});
    gyro_pitch = ($signed({{16{pitch_angle[16]}}, pitch_angle}) <<< 12)
               + $signed({{17{gy[15]}}, gy}) * $signed({17'd0, time_step});
    // pitch takes tilt_b with the roll gyro term, roll takes tilt_a with pitch
    prod_tilt_src = (ZW+5)'(cmd.mult_b ? cz : tilt_a) <<< 4;
    prod_gyro_src = cmd.mult_b ? g_roll_q : g_pitch_q;
    w_s = $signed({2'b00, accel_weight});
    gw_s = $signed(18'sd65536 - w_s);
    acc = 50'(prod_t) + 50'(prod_g) + 50'sd134217728;
    acc_r = 22'(acc >>> 28);
    if (acc_r > 22'(ica_pkg::AngLimit)) blend_q = ica_pkg::AngLimit;
    else if (acc_r < -22'(ica_pkg::AngLimit)) blend_q = -ica_pkg::AngLimit;
    else blend_q = 17'(acc_r);
    yaw_acc = (($signed({{23{yaw_angle[23]}}, yaw_angle}) <<< 12)
            + 47'($signed(gz) * $signed({1'b0, time_step})) + 47'sd2048) >>> 12;
    if (yaw_acc > 47'sd8388607) yaw_sat = 24'sh7FFFFF;
    else if (yaw_acc < -47'sd8388608) yaw_sat = 24'sh800000;
    else yaw_sat = 24'(yaw_acc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= ica_pkg::TimeStepReset;
      accel_weight <= ica_pkg::AccelWeightReset;
      yaw_angle <= '0;
      pitch_angle <= '0;
      roll_angle <= '0;
      sq_cnt <= '0;
      cstep <= '0;
    end else begin
      if (cfg_we) begin
        unique case (ica_pkg::reg_index_t'(cfg_index))
          ica_pkg::REG_TIME_STEP: time_step <= cfg_data;
          ica_pkg::REG_ACCEL_WEIGHT: accel_weight <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        ax <= accel_x; ay <= accel_y; az <= accel_z;
        gx <= gyro_x; gy <= gyro_y; gz <= gyro_z;
        sq_val <= {sq_sum, 16'd0};
        sq_rem <= '0;
        sq_root <= '0;
        sq_cnt <= 5'(ica_pkg::SqrtSteps);
        yaw_prev <= yaw_angle;
        pitch_prev <= pitch_angle;
        roll_prev <= roll_angle;
      end
      if (cmd.sqrt_step && sq_cnt != '0) begin
        // value = (ay^2+az^2)<<16, fed two bits per step from the top
        if (sq_trial_rem >= sq_trial) begin
          sq_rem <= 26'(sq_trial_rem - sq_trial);
          sq_root <= {sq_root[22:0], 1'b1};
        end else begin
          sq_rem <= 26'(sq_trial_rem);
          sq_root <= {sq_root[22:0], 1'b0};
        end
        sq_val <= {sq_val[45:0], 2'b00};
        sq_cnt <= sq_cnt - 5'd1;
      end
      if (cmd.cordic_init_a || cmd.cordic_init_b) begin
        cx <= ix;
        cy <= iy;
        cz <= iz;
        // both operands zero: angle is zero, skip the iterations
        cstep <= (ix == 0 && iy == 0) ? ica_pkg::StepW'(ica_pkg::RunSteps) : '0;
      end
      if (cmd.cordic_step && !status.cordic_done) begin
        if (!cy[CW-1]) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + ica_pkg::atan_entry(cstep);
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - ica_pkg::atan_entry(cstep);
        end
        cstep <= cstep + 1'b1;
      end
      if (cmd.mult_a) begin
        tilt_a <= cz;
        g_roll_q <= gyro_roll;
        g_pitch_q <= gyro_pitch;
      end
      if (cmd.mult_b || cmd.finish) begin
        prod_t <= 49'(w_s * prod_tilt_src);
        prod_g <= 49'(gw_s * prod_gyro_src);
      end
      if (cmd.finish) begin
        pitch_angle <= blend_q;
        pitch_new <= blend_q;
        yaw_angle <= yaw_sat;
        yaw_new <= yaw_sat;
      end
      if (cmd.finish_roll) begin
        roll_angle <= blend_q;
        roll_new <= blend_q;
      end
    end
  end

`ifndef SYNTHESIS
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    (pitch_angle <= ica_pkg::AngLimit) && (pitch_angle >= -ica_pkg::AngLimit))
    else $error("pitch out of range");
  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    (roll_angle <= ica_pkg::AngLimit) && (roll_angle >= -ica_pkg::AngLimit))
    else $error("roll out of range");
  a_load_sqrt: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !status.sqrt_done) else $error("sqrt not started");
`endif

endmodule

### sim/testbench.sv
// Self-checking testbench for the complementary attitude estimator.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic signed [23:0] yaw_n;
    logic signed [16:0] pitch_n;
    logic signed [16:0] roll_n;
    logic signed [23:0] yaw_p;
    logic signed [16:0] pitch_p;
    logic signed [16:0] roll_p;
  } attitude_t;

  // Angle table in degrees, 16 fractional bits.
  function automatic longint atan_deg(input int i);
    longint tbl [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
    return tbl[i];
  endfunction

  class attitude_scoreboard;
    logic [15:0] dt_q16;
    logic [15:0] weight_q16;
    longint yaw_st, pitch_st, roll_st;
    attitude_t pending[$];
    int errors;
    int checked;

    function void clear_state();
      dt_q16 = ica_pkg::TimeStepReset;
      weight_q16 = ica_pkg::AccelWeightReset;
      yaw_st = 0;
      pitch_st = 0;
      roll_st = 0;
    endfunction

    function longint int_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    function longint vector_angle(input longint y, input longint x);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = 90 * 65536;
        end else begin
          t = x; x = -y; y = t; z = -90 * 65536;
        end
      end
      for (int i = 0; i < ica_pkg::RunSteps; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += atan_deg(i);
        end else begin
          x -= ys; y += xs; z -= atan_deg(i);
        end
      end
      return z;
    endfunction

    function longint mix(input longint tilt, input longint gyro);
      longint w, acc, r;
      w = longint'(weight_q16);
      acc = w * (tilt * 16) + (65536 - w) * gyro;
      r = (acc + (64'sd1 <<< 27)) >>> 28;
      if (r > 46080) r = 46080;
      if (r < -46080) r = -46080;
      return r;
    endfunction

    function void note_sample(input logic signed [15:0] ax, ay, az, gx, gy, gz);
      attitude_t e;
      longint dt, mag, ta, tb, yaw;
      longint sax, say, saz;
      dt = longint'(dt_q16);
      sax = ax; say = ay; saz = az;
      e.yaw_p = 24'(yaw_st); e.pitch_p = 17'(pitch_st); e.roll_p = 17'(roll_st);
      mag = int_sqrt(longint'(say * say + saz * saz) << 16);
      ta = vector_angle(-sax * 256, mag);
      tb = vector_angle(say * 256, saz * 256);
      yaw = (yaw_st * 4096 + longint'(gz) * dt + 2048) >>> 12;
      if (yaw > 8388607) yaw = 8388607;
      if (yaw < -8388608) yaw = -8388608;
      begin
        longint np, nr;
        np = mix(tb, roll_st * 4096 + longint'(gx) * dt);
        nr = mix(ta, pitch_st * 4096 + longint'(gy) * dt);
        pitch_st = np;
        roll_st = nr;
      end
      yaw_st = yaw;
      e.yaw_n = 24'(yaw); e.pitch_n = 17'(pitch_st); e.roll_n = 17'(roll_st);
      pending.push_back(e);
    endfunction

    function void check_result(input attitude_t a);
      attitude_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (a.yaw_n !== e.yaw_n) begin
        $error("yaw_new exp %0d got %0d", e.yaw_n, a.yaw_n); errors++;
      end
      if (a.pitch_n !== e.pitch_n) begin
        $error("pitch_new exp %0d got %0d", e.pitch_n, a.pitch_n); errors++;
      end
      if (a.roll_n !== e.roll_n) begin
        $error("roll_new exp %0d got %0d", e.roll_n, a.roll_n); errors++;
      end
      if (a.yaw_p !== e.yaw_p) begin
        $error("yaw_prev exp %0d got %0d", e.yaw_p, a.yaw_p); errors++;
      end
      if (a.pitch_p !== e.pitch_p) begin
        $error("pitch_prev exp %0d got %0d", e.pitch_p, a.pitch_p); errors++;
      end
      if (a.roll_p !== e.roll_p) begin
        $error("roll_prev exp %0d got %0d", e.roll_p, a.roll_p); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic signed [15:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] yaw_new, yaw_prev;
  logic signed [16:0] pitch_new, roll_new, pitch_prev, roll_prev;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  attitude_scoreboard sb = new();
  int idle_cycles = 0;
  int samples_sent = 0;
  bit hold_out = 1'b0;

  imu_complementary_attitude u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 4000) begin
      $display("** imu_complementary_attitude: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{yaw_new, pitch_new, roll_new, yaw_prev, pitch_prev, roll_prev});
  end

  // result side: random stalls, plus a long hold-off when asked
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_out = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  task automatic send_sample(input logic [15:0] ax, ay, az, gx, gy, gz, input int gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_x <= ax; accel_y <= ay; accel_z <= az;
    gyro_x <= gx; gyro_y <= gy; gyro_z <= gz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(ax, ay, az, gx, gy, gz);
    samples_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input ica_pkg::reg_index_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ica_pkg::REG_TIME_STEP) sb.dt_q16 = val;
    else sb.weight_q16 = val;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 8000)) - 4000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
  endfunction

  initial begin
    logic [15:0] dts [4] = '{16'd0, 16'd65535, 16'd3277, 16'd1};
    logic [15:0] wts [4] = '{16'd65535, 16'd0, 16'd64225, 16'd32768};
    sb.clear_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero tilt operands, saturation of pitch and roll
    send_sample(0, 0, 0, 0, 0, 0, 0);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_sample(16'h7fff, 0, 0, 0, 0, 0, 2);
    send_sample(16'h8000, 0, 0, 0, 0, 0, 0);
    send_sample(0, 16'h4000, 16'hc000, 0, 0, 0, 0);
    send_sample(0, 16'hc000, 16'hc000, 0, 0, 0, 3);
    send_sample(0, 0, 16'hc000, 0, 0, 0, 0);
    send_sample(0, 16'h0001, 16'hffff, 0, 0, 0, 0);
    drain();
    write_reg(ica_pkg::REG_ACCEL_WEIGHT, 16'd0);
    write_reg(ica_pkg::REG_TIME_STEP, 16'd65535);
    for (int i = 0; i < 8; i++)
      send_sample(0, 0, 16'd100, 16'h7fff, 16'h7fff, 16'h7fff, 0);
    for (int i = 0; i < 8; i++)
      send_sample(0, 0, 16'd100, 16'h8000, 16'h8000, 16'h8000, 0);
    drain();

    // random phases through several register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(ica_pkg::REG_TIME_STEP, ph < 4 ? dts[ph] : 16'($urandom));
      write_reg(ica_pkg::REG_ACCEL_WEIGHT, ph < 4 ? wts[ph] : 16'($urandom));
      if (ph == 2) hold_out = 1'b1;
      for (int n = 0; n < 100; n++) begin
        send_sample(pick_field(), pick_field(), pick_field(), pick_field(), pick_field(),
                    pick_field(), (n % 40 < 10) ? 0 : pick_gap());
        if (n == 50) begin
          in_valid <= 1'b0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("Sent %0d samples, checked %0d results over 8 register settings,",
             samples_sent, sb.checked);
    $display("including zero tilt, full-scale axes and angle saturation.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** imu_complementary_attitude: PASSED **");
    end else begin
      $display("** imu_complementary_attitude: FAILED **");
    end
    $finish;
  end
endmodule
